// File: sv/range_flip_count_tree_macros.svh
// Assertion macros for the range flip / count block.
// Used by range_flip_count_tree.sv; expects clk and rst_n in scope.
`ifndef RANGE_FLIP_COUNT_TREE_MACROS_SVH
`define RANGE_FLIP_COUNT_TREE_MACROS_SVH

// same-cycle implication
`define RFCT_ASSERT_IMPL(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("rfct check failed");

// next-cycle implication
`define RFCT_ASSERT_NEXT(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("rfct check failed");

`endif

// File: sv/rfct_pkg.sv
// Shared types, constants and helpers for the range flip / count block.
// No dependencies.
package rfct_pkg;

    localparam int WORD_BITS = 32;
    localparam int POS_W     = 17;
    localparam logic [POS_W-1:0] LEN_RESET = 17'd65536;

    localparam logic OP_FLIP  = 1'b0;
    localparam logic OP_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_OP
    } rfct_state_t;

    // SWAR popcount, five dependent steps
    function automatic logic [5:0] popcount32(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
        a = x - ((x >> 1) & 32'h5555_5555);
        b = (a & 32'h3333_3333) + ((a >> 2) & 32'h3333_3333);
        c = (b + (b >> 4)) & 32'h0F0F_0F0F;
        d = c + (c >> 8);
        e = d + (d >> 16);
        return e[5:0];
    endfunction

endpackage

// File: sv/range_flip_count_tree.sv
// Range flip / range count over a row of bits, top level.
// Depends on rfct_pkg and range_flip_count_tree_macros.svh.
//
// The bit row is kept as a memory of 32-bit words; one shared unit walks
// the words of a request one at a time: it reads a word, then modifies or
// counts it. Flips give no result; empty ranges finish in the idle state
// without a walk. After reset a clearing pass zeroes the memory word by
// word; in_ready stays low meanwhile, configuration writes are taken at
// any time. in_ready is high only when idle with no count result waiting.
`include "range_flip_count_tree_macros.svh"

module range_flip_count_tree #(
    parameter int MAX_BITS = 65536
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_write_en,
    input  logic [rfct_pkg::POS_W-1:0] cfg_write_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      operation,
    input  logic [rfct_pkg::POS_W-1:0] range_low,
    input  logic [rfct_pkg::POS_W-1:0] range_high,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [rfct_pkg::POS_W-1:0] ones_count
);
    import rfct_pkg::*;

    localparam int AW     = $clog2(MAX_BITS);
    localparam int PW     = (AW > 5) ? AW : 6;     // position width
    localparam int WAW    = PW - 5;                 // word index width
    localparam int NWORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam logic [31:0] MAX_LEN = 32'(MAX_BITS);

    logic [31:0] mem [NWORDS];

    rfct_state_t        state_reg, state_next;
    logic [POS_W-1:0]   len_reg;
    logic [WAW-1:0]     word_reg, word_next;
    logic [WAW-1:0]     last_word_reg, last_word_next;
    logic [4:0]         lo_bit_reg, lo_bit_next;
    logic [4:0]         hi_bit_reg, hi_bit_next;
    logic               first_reg, first_next;
    logic               op_reg, op_next;
    logic [POS_W-1:0]   acc_reg, acc_next;
    logic               out_valid_reg, out_valid_next;
    logic [POS_W-1:0]   count_reg, count_next;
    logic [31:0]        rd_data_reg;

    logic               mem_we;
    logic [31:0]        mem_wdata;

    // clipped request, zero-based positions
    logic [31:0] len_eff, lo_c, hi_c, lo0, hi0;
    logic        empty;
    logic [PW-1:0] lo_pos, hi_pos;
    logic [31:0] lo_mask, hi_mask, mask;

    always_comb
    begin
        if (len_reg == '0)
            len_eff = 32'd1;
        else if (32'(len_reg) > MAX_LEN)
            len_eff = MAX_LEN;
        else
            len_eff = 32'(len_reg);
        lo_c   = (range_low == '0) ? 32'd1 : 32'(range_low);
        hi_c   = (32'(range_high) > len_eff) ? len_eff : 32'(range_high);
        empty  = lo_c > hi_c;
        lo0    = lo_c - 32'd1;
        hi0    = hi_c - 32'd1;
        lo_pos = lo0[PW-1:0];
        hi_pos = hi0[PW-1:0];
    end

    // word mask: trim below the low bit on the first word, above the high bit on the last
    always_comb
    begin
        lo_mask = first_reg ? (32'hFFFF_FFFF << lo_bit_reg) : 32'hFFFF_FFFF;
        hi_mask = (word_reg == last_word_reg) ?
                  (32'hFFFF_FFFF >> (5'd31 - hi_bit_reg)) : 32'hFFFF_FFFF;
        mask    = lo_mask & hi_mask;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        word_next      = word_reg;
        last_word_next = last_word_reg;
        lo_bit_next    = lo_bit_reg;
        hi_bit_next    = hi_bit_reg;
        first_next     = first_reg;
        op_next        = op_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        mem_we         = 1'b0;
        mem_wdata      = '0;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (word_reg == WAW'(NWORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                    word_next = word_reg + 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = !out_valid_reg;
                if (in_valid && !out_valid_reg)
                begin
                    op_next        = operation;
                    word_next      = lo_pos[PW-1:5];
                    last_word_next = hi_pos[PW-1:5];
                    lo_bit_next    = lo_pos[4:0];
                    hi_bit_next    = hi_pos[4:0];
                    first_next     = 1'b1;
                    acc_next       = '0;
                    if (empty)
                    begin
                        if (operation == OP_COUNT)
                        begin
                            out_valid_next = 1'b1;
                            count_next     = '0;
                        end
                    end
                    else
                        state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_OP;
            end
            ST_OP:
            begin
                if (op_reg == OP_FLIP)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = rd_data_reg ^ mask;
                end
                acc_next   = acc_reg + POS_W'(popcount32(rd_data_reg & mask));
                first_next = 1'b0;
                if (word_reg == last_word_reg)
                begin
                    state_next = ST_IDLE;
                    if (op_reg == OP_COUNT)
                    begin
                        out_valid_next = 1'b1;
                        count_next     = acc_next;
                    end
                end
                else
                begin
                    word_next  = word_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
            len_reg       <= LEN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
                len_reg <= cfg_write_data;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        last_word_reg <= last_word_next;
        lo_bit_reg    <= lo_bit_next;
        hi_bit_reg    <= hi_bit_next;
        first_reg     <= first_next;
        op_reg        <= op_next;
        acc_reg       <= acc_next;
        count_reg     <= count_next;
    end

    // word memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[word_reg] <= mem_wdata;
        rd_data_reg <= mem[word_reg];
    end

    assign out_valid  = out_valid_reg;
    assign ones_count = count_reg;

    `RFCT_ASSERT_IMPL(a_ready_no_result, in_ready, !out_valid_reg)
    `RFCT_ASSERT_IMPL(a_clear_blocks, state_reg == ST_CLEAR, !in_ready)
    `RFCT_ASSERT_NEXT(a_flip_silent, in_valid && in_ready && operation == OP_FLIP,
                      !out_valid_reg)
    `RFCT_ASSERT_IMPL(a_walk_bound, state_reg == ST_OP, word_reg <= last_word_reg)

endmodule

// File: tb/sv/range_flip_count_tree_tb.sv
// Self-checking bench for range_flip_count_tree: flips and counts over bit ranges.
// Depends on rfct_pkg and the range_flip_count_tree RTL; predicts results internally.
`timescale 1ns / 100ps

module range_flip_count_tree_tb;
    import rfct_pkg::*;

    localparam int ROW_BITS  = 65536;
    localparam int ROW_WORDS = ROW_BITS / 32;
    localparam longint CYCLE_LIMIT = 20000000;

    typedef struct packed {
        logic             op;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
    } range_req_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_write_en;
    logic [POS_W-1:0] cfg_write_data;
    logic             in_valid;
    logic             in_ready;
    logic             operation;
    logic [POS_W-1:0] range_low;
    logic [POS_W-1:0] range_high;
    logic             out_valid;
    logic             out_ready;
    logic [POS_W-1:0] ones_count;

    range_flip_count_tree #(.MAX_BITS(ROW_BITS)) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write_en  (cfg_write_en),
        .cfg_write_data(cfg_write_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .range_low     (range_low),
        .range_high    (range_high),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .ones_count    (ones_count)
    );

    // Shadow copy of the bit row plus the length register
    logic [31:0]      row_words [ROW_WORDS];
    logic [POS_W-1:0] shadow_len;

    range_req_t       req_q [$];
    logic [POS_W-1:0] count_q [$];

    int     fail_cnt;
    int     flips_sent;
    int     counts_seen;
    longint cycle_cnt;
    bit     hold_go;
    bit     in_fire;

    // Applies one transfer to the shadow row; returns the count for count requests
    function automatic logic [POS_W-1:0] apply_range(input range_req_t r);
        int len;
        int lo;
        int hi;
        int w;
        int total;
        logic [31:0] mask;
        len   = shadow_len;
        lo    = r.lo;
        hi    = r.hi;
        total = 0;
        if (len < 1) len = 1;
        if (len > ROW_BITS) len = ROW_BITS;
        if (lo < 1) lo = 1;
        if (hi > len) hi = len;
        if (lo > hi) return '0;
        for (w = (lo - 1) >> 5; w <= (hi - 1) >> 5; w++)
        begin
            mask = '1;
            if (w == (lo - 1) >> 5) mask &= 32'hFFFF_FFFF << ((lo - 1) & 31);
            if (w == (hi - 1) >> 5) mask &= 32'hFFFF_FFFF >> (31 - ((hi - 1) & 31));
            if (r.op == OP_FLIP)
                row_words[w] ^= mask;
            else
                total += $countones(row_words[w] & mask);
        end
        return total[POS_W-1:0];
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Input side: fire detection and prediction at the rising edge
    always @(posedge clk)
    begin
        logic [POS_W-1:0] c;
        cycle_cnt++;
        if (rst_n && cfg_write_en) shadow_len = cfg_write_data;
        in_fire = rst_n && in_valid && in_ready;
        if (in_fire)
        begin
            c = apply_range('{operation, range_low, range_high});
            if (operation == OP_COUNT) count_q.push_back(c);
            else flips_sent++;
        end
    end

    // Driver: bursts with random gaps, payload changes on the falling edge
    int burst_left;
    int gap_left;
    always @(negedge clk)
    begin
        range_req_t r;
        if (!rst_n)
        begin
            in_valid = 1'b0;
        end
        else if (in_valid && !in_fire)
        begin
            // hold the offer until it is taken
        end
        else if (gap_left > 0)
        begin
            gap_left--;
            in_valid = 1'b0;
        end
        else if (req_q.size() > 0)
        begin
            r = req_q.pop_front();
            operation  = r.op;
            range_low  = r.lo;
            range_high = r.hi;
            in_valid   = 1'b1;
            if (burst_left > 0) burst_left--;
            else
            begin
                burst_left = $urandom_range(0, 20);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
        else
        begin
            in_valid = 1'b0;
        end
    end

    // Receiver: random stall pattern, re-drawn periodically from the cycle counter; one long hold on request
    int  stall_mode;
    int  hold_left;
    bit  hold_taken;
    always @(negedge clk)
    begin
        if (cycle_cnt % 64 == 0) stall_mode = $urandom_range(0, 2);
        if (hold_go && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = 3000;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready = 1'b0;
        end
        else
        begin
            case (stall_mode)
                0:       out_ready = 1'b1;
                1:       out_ready = 1'($urandom_range(0, 1));
                default: out_ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Monitor: each count transfer checked against the oldest prediction
    always @(posedge clk)
    begin
        logic [POS_W-1:0] want;
        if (rst_n && out_valid && out_ready)
        begin
            counts_seen++;
            if (count_q.size() == 0)
            begin
                $display("%0t: unexpected count transfer, actual %0d", $time, ones_count);
                fail_cnt++;
            end
            else
            begin
                want = count_q.pop_front();
                if (ones_count !== want)
                begin
                    $display("%0t: ones_count mismatch, expected %0d actual %0d",
                             $time, want, ones_count);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d counts still expected", $time, count_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic push_req(input logic op, input int lo, input int hi);
        req_q.push_back('{op, lo[POS_W-1:0], hi[POS_W-1:0]});
    endtask

    // Waits for the block to drain completely
    task automatic wait_drained();
        do @(posedge clk);
        while (req_q.size() != 0 || in_valid || count_q.size() != 0 || !in_ready);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_length(input int len);
        @(negedge clk);
        cfg_write_en   = 1'b1;
        cfg_write_data = len[POS_W-1:0];
        @(negedge clk);
        cfg_write_en   = 1'b0;
    endtask

    // Random traffic scaled to the active length; mostly short spans
    task automatic random_phase(input int len, input int n);
        int eff;
        int lo;
        int hi;
        eff = (len < 1) ? 1 : (len > ROW_BITS ? ROW_BITS : len);
        repeat (n)
        begin
            case ($urandom_range(0, 9))
                0:
                begin                        // raw noise over the whole field
                    lo = $urandom_range(0, 131071);
                    hi = $urandom_range(0, 131071);
                end
                1:
                begin                        // edges and empty ranges
                    lo = $urandom_range(0, 2) == 0 ? 0 : eff;
                    hi = $urandom_range(0, 1) ? eff + $urandom_range(0, 3) : lo - 1;
                end
                2:
                begin                        // wide span, kept rare
                    lo = $urandom_range(0, eff);
                    hi = $urandom_range(lo, eff + 2);
                end
                default:
                begin
                    lo = $urandom_range(0, eff + 1);
                    hi = lo + $urandom_range(0, (eff < 300) ? eff : 300);
                end
            endcase
            if (hi < 0) hi = 0;
            push_req(1'($urandom_range(0, 1)), lo, hi);
        end
    endtask

    initial
    begin
        int lens [8] = '{37, 0, 1, 2, 131071, 1000, 70000, 65536};
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        operation      = OP_FLIP;
        range_low      = '0;
        range_high     = '0;
        out_ready      = 1'b0;
        shadow_len     = LEN_RESET;
        foreach (row_words[i]) row_words[i] = '0;
        fail_cnt = 0; flips_sent = 0; counts_seen = 0; cycle_cnt = 0;
        burst_left = 0; gap_left = 0; stall_mode = 0; in_fire = 1'b0;
        hold_left = 0; hold_taken = 1'b0; hold_go = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: full row, clipping, empty ranges, end positions
        push_req(OP_COUNT, 1, 65536);
        push_req(OP_FLIP, 1, 65536);
        push_req(OP_COUNT, 1, 65536);
        push_req(OP_COUNT, 0, 131071);
        push_req(OP_FLIP, 0, 0);
        push_req(OP_COUNT, 5, 3);
        push_req(OP_FLIP, 1, 1);
        push_req(OP_COUNT, 1, 1);
        push_req(OP_FLIP, 65536, 65536);
        push_req(OP_COUNT, 65535, 65536);
        push_req(OP_COUNT, 131071, 131071);
        push_req(OP_FLIP, 31, 33);
        push_req(OP_COUNT, 30, 34);
        push_req(OP_FLIP, 100, 131071);
        push_req(OP_COUNT, 0, 200);
        wait_drained();

        // Length sweep; cells survive length changes
        foreach (lens[p])
        begin
            write_length(lens[p]);
            random_phase(lens[p], 180);
            if (p == 5)
            begin
                repeat (50) @(posedge clk);
                hold_go = 1'b1;
            end
            wait_drained();
        end

        $display("Covered %0d flips and %0d counts over %0d length settings",
                 flips_sent, counts_seen, $size(lens) + 1);
        if (fail_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
+incdir+sv
sv/rfct_pkg.sv
sv/range_flip_count_tree.sv
tb/sv/range_flip_count_tree_tb.sv
